/* sv/bloom_filter_jenkins_mix_top_assert.svh */
// Assertion macros for the bloom filter checker.
// Needs clock and reset names passed by the user of each macro.
`ifndef BLOOM_FILTER_JENKINS_MIX_TOP_ASSERT_SVH
`define BLOOM_FILTER_JENKINS_MIX_TOP_ASSERT_SVH
// implication check, disabled in reset
`define BF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication check
`define BF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* sv/bfjm_pkg.sv */
// Package for the bloom filter: kind codes, register indexes, mix function.
// No dependencies.
`default_nettype none
package bfjm_pkg;
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_LOAD   = 2'd2;
   localparam logic [2:0] REG_KEYS_IN_USE  = 3'd6;
   localparam logic [2:0] REG_FILTER_BYTES = 3'd7;
   localparam int KEY_REGS = 6;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } mix_state_type;

   // one mix round: step 0..2 selects shift amounts
   function automatic mix_state_type mix_round(mix_state_type s, logic [1:0] step);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      mix_state_type r;
      a = s.a;
      b = s.b;
      c = s.c;
      case (step)
         2'd0: begin
            a = a - (b + c); a = a ^ (c >> 13);
            b = b - (c + a); b = b ^ (a << 8);
            c = c - (a + b); c = c ^ (b >> 13);
         end
         2'd1: begin
            a = a - (b + c); a = a ^ (c >> 12);
            b = b - (c + a); b = b ^ (a << 16);
            c = c - (a + b); c = c ^ (b >> 5);
         end
         default: begin
            a = a - (b + c); a = a ^ (c >> 3);
            b = b - (c + a); b = b ^ (a << 10);
            c = c - (a + b); c = c ^ (b >> 15);
         end
      endcase
      r.a = a;
      r.b = b;
      r.c = c;
      return r;
   endfunction
endpackage
`default_nettype wire

/* sv/bloom_filter_jenkins_mix_top.sv */
// Bloom filter top level: sequencer, key registers, mix, modulo unit, store.
// Depends on bfjm_pkg, bfjm_modulo, bfjm_store.
//
// Usage:
//   req_* carries one item (insert, query, load byte). rsp_* returns one beat
//   per item: done_kind echoes kind, present is set for a query whose chosen
//   bits are all set.
//   csr_* writes registers 0..5 (keys), 6 (keys_in_use), 7 (filter_bytes).
//   The user writes them only while the block is idle; the block does not enforce it.
//   After reset a clearing pass writes zero to every store byte, during which
//   req_ready is low.
//   Per key the sequencer runs the mix rounds, the serial remainder unit, then
//   a read step and a modify/write step; a load, unused kind or zero keys skips
//   them. rsp_valid rises and req_ready returns in the same cycle; the serial
//   remainder unit takes most of the time per key. One item is in flight.
//   The result sits in an output register; if rsp_ready is low it holds there
//   while the next item is already accepted and processed, and that item waits
//   only to present its own result.
`default_nettype none
module bloom_filter_jenkins_mix_top #(
   parameter int MAX_KEYS  = 6,
   parameter int MAX_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_prefix,
   input  wire logic [11:0] req_byte_address,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_done_kind,
   output logic             rsp_present,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import bfjm_pkg::*;
   localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CW = $clog2(MAX_BYTES + 1);
   localparam int LIM = (MAX_KEYS < KEY_REGS) ? MAX_KEYS : KEY_REGS;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MIX, ST_MOD, ST_WAIT, ST_READ, ST_MODIFY, ST_DONE
   } state_type;

   state_type     state_ff;
   logic [63:0]   key_ff [KEY_REGS];
   logic [2:0]    nkeys_ff;
   logic [12:0]   fbytes_ff;
   logic [CW-1:0] clr_ff;
   logic [1:0]    kind_ff;
   logic [31:0]   prefix_ff;
   logic [2:0]    ki_ff;
   logic [1:0]    step_ff;
   mix_state_type mix_ff;
   logic          all_ff;
   logic [15:0]   idx_ff;
   logic          rv_ff;
   logic [1:0]    rk_ff;
   logic          rp_ff;

   logic [2:0]    nk_eff;
   logic [12:0]   fb_eff;
   logic [15:0]   modulus;
   logic          mod_start, mod_done;
   logic [15:0]   mod_rem;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic [7:0]    mask;
   logic          in_range;
   mix_state_type mix_next;

   always_comb begin
      nk_eff = (nkeys_ff > 3'(LIM)) ? 3'(LIM) : nkeys_ff;
      if (fbytes_ff == 13'd0) fb_eff = 13'd1;
      else if (32'(fbytes_ff) > MAX_BYTES) fb_eff = 13'(MAX_BYTES);
      else fb_eff = fbytes_ff;
      modulus = {fb_eff, 3'b000};
   end

   assign mix_next = mix_round(mix_ff, step_ff);
   assign in_range = (32'(idx_ff[15:3]) < MAX_BYTES);
   assign mask     = 8'(1) << idx_ff[2:0];
   assign rd_addr  = AW'(idx_ff[15:3]);
   assign mod_start = (state_ff == ST_MIX) && (step_ff == 2'd2);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr;
      wr_data = rd_data | mask;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = AW'(clr_ff);
         wr_data = 8'd0;
      end else if (state_ff == ST_IDLE && req_valid && req_ready && req_kind == KIND_LOAD
                   && 32'(req_byte_address) < MAX_BYTES) begin
         wr_en   = 1'b1;
         wr_addr = AW'(req_byte_address);
         wr_data = req_byte_value;
      end else if (state_ff == ST_MODIFY && kind_ff == KIND_INSERT && in_range) begin
         wr_en = 1'b1;
      end
   end

   bfjm_modulo u_mod (
      .clock, .reset, .start(mod_start),
      .dividend(mix_next.c), .modulus, .done(mod_done), .remainder(mod_rem)
   );

   bfjm_store #(.MAX_BYTES(MAX_BYTES), .AW(AW)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_done_kind = rk_ff;
   assign rsp_present   = rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         nkeys_ff  <= 3'd6;
         fbytes_ff <= 13'd4096;
         for (int i = 0; i < KEY_REGS; i++) key_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_KEYS_IN_USE) nkeys_ff <= csr_data[2:0];
            else if (csr_index == REG_FILTER_BYTES) fbytes_ff <= csr_data[12:0];
            else key_ff[csr_index] <= csr_data;
         end
         if (state_ff == ST_DONE && (!rv_ff || rsp_ready)) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + CW'(1);
               if (32'(clr_ff) == MAX_BYTES - 1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req_kind;
                  prefix_ff <= req_prefix;
                  ki_ff     <= 3'd0;
                  all_ff    <= 1'b1;
                  if ((req_kind == KIND_INSERT || req_kind == KIND_QUERY)
                      && nk_eff != 3'd0) begin
                     state_ff <= ST_MIX;
                     step_ff  <= 2'd0;
                     mix_ff.a <= key_ff[0][31:0];
                     mix_ff.b <= key_ff[0][63:32];
                     mix_ff.c <= req_prefix;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_MIX: begin
               mix_ff  <= mix_next;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd2) state_ff <= ST_MOD;
            end
            ST_MOD: begin
               if (mod_done) begin
                  idx_ff   <= mod_rem;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_MODIFY;
            ST_MODIFY: begin
               if (kind_ff == KIND_QUERY && in_range && (rd_data & mask) == 8'd0)
                  all_ff <= 1'b0;
               if (ki_ff + 3'd1 >= nk_eff) begin
                  state_ff <= ST_DONE;
               end else begin
                  ki_ff    <= ki_ff + 3'd1;
                  state_ff <= ST_MIX;
                  step_ff  <= 2'd0;
                  mix_ff.a <= key_ff[ki_ff + 3'd1][31:0];
                  mix_ff.b <= key_ff[ki_ff + 3'd1][63:32];
                  mix_ff.c <= prefix_ff;
               end
            end
            ST_DONE: begin
               if (!rv_ff || rsp_ready) begin
                  rk_ff    <= kind_ff;
                  rp_ff    <= (kind_ff == KIND_QUERY) && all_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* sv/bfjm_modulo.sv */
// Restoring divider remainder unit: 32-bit value modulo a runtime modulus.
// One quotient bit per cycle. Uses nothing from the package.
`default_nettype none
module bfjm_modulo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] modulus,
   output logic             done,
   output logic [15:0]      remainder
);
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, modulus}) rem_in = trial - {1'b0, modulus};
         else rem_in = trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[15:0];
endmodule
`default_nettype wire

/* sv/bfjm_store.sv */
// Bit store memory: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module bfjm_store #(
   parameter int MAX_BYTES = 4096,
   parameter int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);
   logic [7:0] mem [MAX_BYTES];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/bfjm_checker.sv */
// Port-level checker for the bloom filter top level, with its bind.
// Depends on bloom_filter_jenkins_mix_top_assert.svh and bfjm_pkg.
`default_nettype none
`include "bloom_filter_jenkins_mix_top_assert.svh"
module bfjm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_done_kind,
   input wire logic       rsp_present
);
   import bfjm_pkg::*;
   `BF_ASSERT_IMP(a_present_query, clock, reset, rsp_valid && rsp_present, rsp_done_kind == KIND_QUERY)
   `BF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_done_kind))
   `BF_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready, !req_ready)
   `BF_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)
endmodule

bind bloom_filter_jenkins_mix_top bfjm_checker u_bfjm_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_done_kind, .rsp_present
);
`default_nettype wire

/* verif/bloom_filter_jenkins_mix_top_tb.sv */
// Testbench for bloom_filter_jenkins_mix_top: directed and random inserts, queries
// and byte loads checked against an in-bench Jenkins-mix bloom filter predictor.
// Depends on bfjm_pkg and the top level only.
`timescale 1ns / 100ps
module bloom_filter_jenkins_mix_top_tb;
   import bfjm_pkg::*;

   localparam int N_KEYS = 6;
   localparam int N_BYTES = 4096;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] prefix;
      logic [11:0] addr;
      logic [7:0]  value;
   } filter_op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       present;
   } filter_ack_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic [31:0] req_prefix = '0;
   logic [11:0] req_byte_address = '0;
   logic [7:0] req_byte_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_done_kind;
   logic rsp_present;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   filter_op_type op_queue[$];
   filter_ack_type ack_queue[$];
   logic [63:0] key_shadow[N_KEYS];
   logic [2:0] keys_shadow;
   logic [12:0] bytes_shadow;
   logic [7:0] store_shadow[N_BYTES];
   int mismatches = 0;
   int issued = 0;
   bit calm = 1'b0;
   bit cfg_busy = 1'b0;

   bloom_filter_jenkins_mix_top DUT (.*);

   always #5 clock = ~clock;

   function automatic void add_op(filter_op_type op);
      op_queue.insert(op_queue.size(), op);
   endfunction

   function automatic logic [31:0] jenkins_mix(logic [63:0] key, logic [31:0] c);
      logic [31:0] a;
      logic [31:0] b;
      a = key[31:0];
      b = key[63:32];
      a -= b + c; a ^= c >> 13;
      b -= c + a; b ^= a << 8;
      c -= a + b; c ^= b >> 13;
      a -= b + c; a ^= c >> 12;
      b -= c + a; b ^= a << 16;
      c -= a + b; c ^= b >> 5;
      a -= b + c; a ^= c >> 3;
      b -= c + a; b ^= a << 10;
      c -= a + b; c ^= b >> 15;
      return c;
   endfunction

   function automatic filter_ack_type apply_filter_op(filter_op_type op);
      filter_ack_type r;
      int nk;
      int nbits;
      logic [31:0] idx;
      bit all;
      r.kind = op.kind;
      r.present = 1'b0;
      nk = (keys_shadow > N_KEYS) ? N_KEYS : keys_shadow;
      nbits = (bytes_shadow == 0) ? 8 : (bytes_shadow > N_BYTES) ? N_BYTES * 8
         : bytes_shadow * 8;
      all = 1'b1;
      if (op.kind == KIND_INSERT || op.kind == KIND_QUERY) begin
         for (int i = 0; i < nk; i++) begin
            idx = jenkins_mix(key_shadow[i], op.prefix) % nbits;
            if (op.kind == KIND_INSERT)
               store_shadow[idx / 8][idx % 8] = 1'b1;
            else if (!store_shadow[idx / 8][idx % 8])
               all = 1'b0;
         end
         if (op.kind == KIND_QUERY) r.present = all;
      end else if (op.kind == KIND_LOAD) begin
         store_shadow[op.addr] = op.value;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (req_valid) issued++;
            if (op_queue.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
               req_valid <= 1'b1;
               req_kind <= op_queue[0].kind;
               req_prefix <= op_queue[0].prefix;
               req_byte_address <= op_queue[0].addr;
               req_byte_value <= op_queue[0].value;
               ack_queue.insert(ack_queue.size(), apply_filter_op(op_queue.pop_front()));
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 21);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ack_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat kind=%0d", rsp_done_kind);
         end else if (ack_queue[0].kind !== rsp_done_kind
               || ack_queue[0].present !== rsp_present) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind=%0d present=%0d got kind=%0d present=%0d",
                  ack_queue[0].kind, ack_queue[0].present, rsp_done_kind, rsp_present);
            void'(ack_queue.pop_front());
         end else begin
            void'(ack_queue.pop_front());
         end
      end
   end

   task automatic write_reg(logic [2:0] index, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index < N_KEYS) key_shadow[index] = value;
      else if (index == REG_KEYS_IN_USE) keys_shadow = value[2:0];
      else bytes_shadow = value[12:0];
   endtask

   task automatic drain_filter();
      while (op_queue.size() > 0 || req_valid || ack_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic filter_op_type rand_op(int hot);
      filter_op_type op;
      int r;
      r = $urandom_range(99);
      op.kind = (r < 40) ? KIND_INSERT : (r < 85) ? KIND_QUERY : (r < 97) ? KIND_LOAD
         : KIND_UNUSED;
      op.prefix = (hot > 0 && $urandom_range(1)) ? 32'($urandom_range(hot - 1))
         : $urandom;
      op.addr = (bytes_shadow != 0 && $urandom_range(3) != 0)
         ? 12'($urandom_range(bytes_shadow - 1)) : 12'($urandom);
      op.value = 8'($urandom);
      return op;
   endfunction

   initial begin
      filter_op_type op;
      for (int i = 0; i < N_KEYS; i++) key_shadow[i] = '0;
      keys_shadow = 3'd6;
      bytes_shadow = 13'd4096;
      foreach (store_shadow[i]) store_shadow[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset config, extremes, every kind
      add_op('{KIND_QUERY, 32'h0, 12'h0, 8'h0});
      add_op('{KIND_INSERT, 32'h0, 12'hfff, 8'hff});
      add_op('{KIND_QUERY, 32'h0, 12'h0, 8'h0});
      add_op('{KIND_INSERT, 32'hffffffff, 12'h0, 8'h0});
      add_op('{KIND_QUERY, 32'hffffffff, 12'h0, 8'h0});
      add_op('{KIND_LOAD, 32'hffffffff, 12'hfff, 8'hff});
      add_op('{KIND_LOAD, 32'h0, 12'h0, 8'haa});
      add_op('{KIND_UNUSED, 32'h12345678, 12'h555, 8'h55});
      add_op('{KIND_QUERY, 32'h12345678, 12'h0, 8'h0});
      drain_filter();

      write_reg(3'd0, 64'hffffffffffffffff);
      write_reg(3'd1, 64'h0123456789abcdef);
      write_reg(3'd2, 64'h8000000000000001);
      write_reg(3'd3, {$urandom, $urandom});
      write_reg(3'd4, {$urandom, $urandom});
      write_reg(3'd5, {$urandom, $urandom});
      write_reg(REG_KEYS_IN_USE, 64'd0);
      write_reg(REG_FILTER_BYTES, 64'd0);
      add_op('{KIND_INSERT, 32'h1, 12'h0, 8'h0});
      add_op('{KIND_QUERY, 32'h2, 12'h0, 8'h0});
      drain_filter();
      write_reg(REG_KEYS_IN_USE, 64'd7);
      add_op('{KIND_QUERY, 32'h3, 12'h0, 8'h0});
      add_op('{KIND_INSERT, 32'h3, 12'h0, 8'h0});
      add_op('{KIND_QUERY, 32'h3, 12'h0, 8'h0});
      drain_filter();
      write_reg(REG_FILTER_BYTES, 64'h1fff);
      add_op('{KIND_INSERT, 32'hdeadbeef, 12'h0, 8'h0});
      add_op('{KIND_QUERY, 32'hdeadbeef, 12'h0, 8'h0});
      drain_filter();

      // random phases over several settings
      for (int ph = 0; ph < 9; ph++) begin
         write_reg(REG_KEYS_IN_USE, (ph == 0) ? 64'd1 : (ph == 1) ? 64'd6
            : 64'($urandom_range(7)));
         write_reg(REG_FILTER_BYTES, (ph == 0) ? 64'd1 : (ph == 1) ? 64'd4096
            : (ph == 2) ? 64'h1fff : 64'($urandom_range(64, 1)));
         write_reg(3'($urandom_range(5)), {$urandom, $urandom});
         calm = (ph == 4);
         for (int n = 0; n < 100; n++) begin
            op = rand_op(40);
            add_op(op);
         end
         drain_filter();
      end
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end
endmodule
